// ===== rtl/hav_pkg.sv =====
//------------------------------------------------------------------------------
// Haversine package
// Shared widths, fixed-point constants and the CORDIC angle table.
//------------------------------------------------------------------------------
package hav_pkg;

	localparam int LatW      = 31;
	localparam int LonW      = 32;
	localparam int RadW      = 23;
	localparam int DistW     = 35;
	// Internal datapath width for Q30 values and wide angle arithmetic.
	localparam int DW        = 64;
	// Sines, cosines and their products stay within one in Q30, so they fit in
	// 32 signed bits.
	localparam int MulW      = 32;
	localparam int CordicItersDefault = 32;
	localparam logic [RadW-1:0] RadiusReset = 23'd6371000;

	localparam logic signed [DW-1:0] Q30One       = 64'sd1073741824;
	localparam logic signed [DW-1:0] CordicGain   = 64'sd652032874;
	localparam logic [DW-1:0]        UnitToRad    = 64'd4024455254;
	localparam logic signed [DW-1:0] FullTurn     = 64'sd7200000000;
	localparam logic signed [DW-1:0] HalfTurn     = 64'sd3600000000;
	localparam logic signed [DW-1:0] QuarterTurn  = 64'sd1800000000;
	localparam logic [DistW-1:0]     DistMax      = 35'd26353590000;

	// Stage angle atan(2^-i) in Q30.
	function automatic logic signed [DW-1:0] atan_step(input int i);
		logic signed [DW-1:0] r;
		begin
			case (i)
				0: r = 64'sd843314856;
				1: r = 64'sd497837829;
				2: r = 64'sd263043836;
				3: r = 64'sd133525158;
				4: r = 64'sd67021686;
				5: r = 64'sd33543515;
				6: r = 64'sd16775850;
				7: r = 64'sd8388437;
				8: r = 64'sd4194282;
				9: r = 64'sd2097149;
				10: r = 64'sd1048575;
				default: r = (i <= 30) ? (64'sd1 <<< (30 - i)) : 64'sd0;
			endcase
			return r;
		end
	endfunction

	// Rounded Q30 product of two 32-bit signed operands.
	function automatic logic signed [DW-1:0] mul_q30(input logic signed [MulW-1:0] a,
		input logic signed [MulW-1:0] b);
		logic signed [DW-1:0] p;
		begin
			p = a * b;
			p = p + 64'sd536870912;
			return p >>> 30;
		end
	endfunction

	// Per-stage sideband for the angle pipeline.
	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
	} rot_t;

endpackage

// ===== rtl/haversine_distance_unit.sv =====
//------------------------------------------------------------------------------
// Haversine distance unit
// Great-circle distance between two points, fully pipelined.
//------------------------------------------------------------------------------
// Takes one pair of points per clock while not stalled and returns distance_mm
// through the pipeline stages: angle reduction and sine/cosine CORDIC, products
// and clamp, square root, atan2 CORDIC and scaling, the last of which is the
// output register. The whole pipeline advances together whenever the output is
// not held by stall, so throughput is one pair per cycle.
module haversine_distance_unit #(
	parameter int CORDIC_ITERATIONS = hav_pkg::CordicItersDefault
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [hav_pkg::LatW-1:0]    lat_a,
	input  logic signed [hav_pkg::LonW-1:0]    lon_a,
	input  logic signed [hav_pkg::LatW-1:0]    lat_b,
	input  logic signed [hav_pkg::LonW-1:0]    lon_b,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [hav_pkg::DistW-1:0]          distance_mm,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hav_pkg::RadW-1:0]           cfg_data
);
	import hav_pkg::*;

	localparam int Depth = 2 + CORDIC_ITERATIONS + 3 + 32 + CORDIC_ITERATIONS + 3;

	logic                  en;
	logic [RadW-1:0]       radius_q;
	logic [Depth-2:0]      vld_q;
	logic signed [DW-1:0]  s_lat, s_lon, c_a, c_b, d0, d1, d2, d3;
	logic signed [DW-1:0]  sl2_s1, cab_s1, so2_s1;
	logic signed [DW-1:0]  a_s2, a_s3;
	logic signed [DW-1:0]  ra, rb;
	rot_t                  vs [CORDIC_ITERATIONS+1];
	logic [31:0]           c_ang;
	logic [DW-1:0]         p_s1, mm_s2;

	// The pipeline moves unless a finished beat is held at the output.
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RadiusReset;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[Depth-3:0], in_valid};
			out_valid <= vld_q[Depth-2];
		end
	end

	// Four parallel sine/cosine units.
	hav_sincos #(.ITERS(CORDIC_ITERATIONS)) u_dlat (.clk, .en,
		.u(DW'(lat_b) - DW'(lat_a)), .sin_o(s_lat), .cos_o(d0));
	hav_sincos #(.ITERS(CORDIC_ITERATIONS)) u_dlon (.clk, .en,
		.u(DW'(lon_b) - DW'(lon_a)), .sin_o(s_lon), .cos_o(d1));
	hav_sincos #(.ITERS(CORDIC_ITERATIONS)) u_lata (.clk, .en,
		.u(DW'(lat_a) <<< 1), .sin_o(d2), .cos_o(c_a));
	hav_sincos #(.ITERS(CORDIC_ITERATIONS)) u_latb (.clk, .en,
		.u(DW'(lat_b) <<< 1), .sin_o(d3), .cos_o(c_b));

	// Products of the haversine term, one multiply level per stage, then the clamp.
	always_ff @(posedge clk) begin
		if (en) begin
			sl2_s1 <= mul_q30(MulW'(s_lat), MulW'(s_lat));
			cab_s1 <= mul_q30(MulW'(c_a), MulW'(c_b));
			so2_s1 <= mul_q30(MulW'(s_lon), MulW'(s_lon));
			a_s2   <= sl2_s1 + mul_q30(MulW'(cab_s1), MulW'(so2_s1));
			a_s3   <= (a_s2 < 0) ? '0 : ((a_s2 > Q30One) ? Q30One : a_s2);
		end
	end

	logic unused_cos;
	assign unused_cos = ^{d0, d1, d2, d3};

	hav_sqrt u_sqa (.clk, .en, .v(a_s3), .root(rb));
	hav_sqrt u_sqb (.clk, .en, .v(Q30One - a_s3), .root(ra));

	// Vectoring CORDIC for atan2(sqrt(a), sqrt(1-a)).
	assign vs[0].x = ra;
	assign vs[0].y = rb;
	assign vs[0].z = '0;

	for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				if (vs[i].y >= 0) begin
					vs[i+1].x <= vs[i].x + (vs[i].y >>> i);
					vs[i+1].y <= vs[i].y - (vs[i].x >>> i);
					vs[i+1].z <= vs[i].z + atan_step(i);
				end else begin
					vs[i+1].x <= vs[i].x - (vs[i].y >>> i);
					vs[i+1].y <= vs[i].y + (vs[i].x >>> i);
					vs[i+1].z <= vs[i].z - atan_step(i);
				end
			end
		end
	end

	// The central angle is at most pi in Q30, so it fits in 32 unsigned bits.
	assign c_ang = (vs[CORDIC_ITERATIONS].z < 0) ? '0 :
		32'(vs[CORDIC_ITERATIONS].z <<< 1);

	// Scale by the radius and convert to millimetres.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= DW'(radius_q) * DW'(c_ang);
			mm_s2 <= (p_s1 >> 30) * 64'd1000 +
				((((p_s1 & 64'h3FFF_FFFF) * 64'd1000) + 64'd536870912) >> 30);
			distance_mm <= (mm_s2 > DW'(DistMax)) ? DistMax : mm_s2[DistW-1:0];
		end
	end

	// A held output beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance_mm))
		else $error("held output changed");
	// Input is stalled exactly when the output holds a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("stall mismatch");
	// Results never exceed the saturation limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_mm <= DistMax)
		else $error("distance above limit");

endmodule

// ===== rtl/hav_sincos.sv =====
//------------------------------------------------------------------------------
// Haversine sine/cosine pipeline
// Angle reduction (two stages) then one rotation CORDIC iteration per stage.
//------------------------------------------------------------------------------
module hav_sincos #(
	parameter int ITERS = hav_pkg::CordicItersDefault
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [hav_pkg::DW-1:0]   u,
	output logic signed [hav_pkg::DW-1:0]   sin_o,
	output logic signed [hav_pkg::DW-1:0]   cos_o
);
	import hav_pkg::*;

	logic signed [DW-1:0] r0, r1;
	logic signed [DW-1:0] r_s1;
	logic                 neg_s1;
	logic [31:0]          m_s1;
	logic signed [DW-1:0] z2;
	logic [DW-1:0]        prod;
	rot_t                 st [ITERS+1];
	logic                 neg_st [ITERS+1];

	// Reduce into (-180, 180] degrees. Every angle fed here is smaller than a
	// full turn in magnitude, so one correction is enough.
	always_comb begin
		r0 = u;
		r1 = r0;
		if (r0 > HalfTurn) r1 = r0 - FullTurn;
		if (r0 <= -HalfTurn) r1 = r0 + FullTurn;
	end

	// Stage 1: fold into [-90, 90] degrees and record whether the fold negates.
	always_ff @(posedge clk) begin
		if (en) begin
			if (r1 > QuarterTurn) begin
				neg_s1 <= 1'b1;
				r_s1   <= r1 - HalfTurn;
			end else if (r1 < -QuarterTurn) begin
				neg_s1 <= 1'b1;
				r_s1   <= r1 + HalfTurn;
			end else begin
				neg_s1 <= 1'b0;
				r_s1   <= r1;
			end
		end
	end

	// Stage 2: convert to radians Q30.
	assign m_s1 = (r_s1 < 0) ? 32'(-r_s1) : 32'(r_s1);
	assign prod = (DW'(m_s1) * UnitToRad + 64'd2147483648) >> 32;
	assign z2   = (r_s1 < 0) ? -$signed(prod) : $signed(prod);

	always_ff @(posedge clk) begin
		if (en) begin
			st[0].x   <= CordicGain;
			st[0].y   <= '0;
			st[0].z   <= z2;
			neg_st[0] <= neg_s1;
		end
	end

	// Rotation CORDIC stages.
	for (genvar i = 0; i < ITERS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				neg_st[i+1] <= neg_st[i];
				if (st[i].z >= 0) begin
					st[i+1].x <= st[i].x - (st[i].y >>> i);
					st[i+1].y <= st[i].y + (st[i].x >>> i);
					st[i+1].z <= st[i].z - atan_step(i);
				end else begin
					st[i+1].x <= st[i].x + (st[i].y >>> i);
					st[i+1].y <= st[i].y - (st[i].x >>> i);
					st[i+1].z <= st[i].z + atan_step(i);
				end
			end
		end
	end

	assign sin_o = neg_st[ITERS] ? -st[ITERS].y : st[ITERS].y;
	assign cos_o = neg_st[ITERS] ? -st[ITERS].x : st[ITERS].x;

endmodule

// ===== rtl/hav_sqrt.sv =====
//------------------------------------------------------------------------------
// Haversine square root
// Pipelined floor root of v*2^30, one result bit per stage.
//------------------------------------------------------------------------------
module hav_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [hav_pkg::DW-1:0] v,
	output logic signed [hav_pkg::DW-1:0] root
);
	import hav_pkg::*;

	localparam int Steps = 32;

	logic [DW-1:0] n_st   [Steps+1];
	logic [DW-1:0] res_st [Steps+1];

	assign n_st[0]   = DW'(v) << 30;
	assign res_st[0] = '0;

	// Each stage handles one bit pair of the radicand.
	for (genvar k = 0; k < Steps; k++) begin : g_bit
		localparam logic [DW-1:0] Bit = 64'd1 << (62 - 2 * k);
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_st[k] >= res_st[k] + Bit) begin
					n_st[k+1]   <= n_st[k] - (res_st[k] + Bit);
					res_st[k+1] <= (res_st[k] >> 1) + Bit;
				end else begin
					n_st[k+1]   <= n_st[k];
					res_st[k+1] <= res_st[k] >> 1;
				end
			end
		end
	end

	assign root = $signed(res_st[Steps]);

endmodule

// ===== test/haversine_checker.sv =====
//------------------------------------------------------------------------------
// Haversine distance checker
// Watches the input, output and radius channels, predicts each distance in
// fixed point and compares it with the beat the block returns.
//------------------------------------------------------------------------------
module haversine_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [hav_pkg::LatW-1:0]     lat_a,
	input  logic signed [hav_pkg::LonW-1:0]     lon_a,
	input  logic signed [hav_pkg::LatW-1:0]     lat_b,
	input  logic signed [hav_pkg::LonW-1:0]     lon_b,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [hav_pkg::DistW-1:0]           distance_mm,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [hav_pkg::RadW-1:0]            cfg_data,
	output int                                  fail_count,
	output int                                  pending_count
);
	import hav_pkg::*;

	localparam int Iters = CordicItersDefault;

	logic [RadW-1:0]  radius_m;
	logic [DistW-1:0] expected_distances[$];

	// Arithmetic shift right, rounding toward minus infinity.
	function automatic longint shr_floor(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint stage_angle(input int i);
		longint head[11] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575};
		if (i < 11)
			return head[i];
		if (i <= 30)
			return longint'(1) << (30 - i);
		return 0;
	endfunction

	function automatic longint q30_product(input longint a, input longint b);
		return (a * b + (longint'(1) << 29)) >>> 30;
	endfunction

	// Sine and cosine of an angle in units of 5e-8 degree.
	task automatic rotate_angle(input longint u, output longint s, output longint c);
		longint r, x, y, z, dx, dy;
		bit folded, minus;
		logic [63:0] m;
		r = u % 64'sd7200000000;
		folded = 0;
		x = 652032874;
		y = 0;
		if (r > 64'sd3600000000)
			r -= 64'sd7200000000;
		if (r <= -64'sd3600000000)
			r += 64'sd7200000000;
		if (r > 64'sd1800000000) begin
			r -= 64'sd3600000000;
			folded = 1;
		end else if (r < -64'sd1800000000) begin
			r += 64'sd3600000000;
			folded = 1;
		end
		minus = r < 0;
		m = minus ? -r : r;
		z = longint'((m * 64'd4024455254 + (64'd1 << 31)) >> 32);
		if (minus)
			z = -z;
		for (int i = 0; i < Iters; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= stage_angle(i);
			end else begin
				x += dx; y -= dy; z += stage_angle(i);
			end
		end
		s = folded ? -y : y;
		c = folded ? -x : x;
	endtask

	// Floor square root of a Q30 value, result in Q30.
	function automatic longint root_q30(input longint v);
		logic [63:0] n, res, b;
		n = v << 30;
		res = 0;
		b = 64'd1 << 62;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	task automatic predict_distance(input longint la, input longint oa, input longint lb,
		input longint ob, input logic [RadW-1:0] rad, output logic [DistW-1:0] exp_mm);
		longint s_lat, s_lon, c_a, c_b, unused, a, x, y, z, dx, dy;
		logic [63:0] p, mm;
		z = 0;
		rotate_angle(lb - la, s_lat, unused);
		rotate_angle(ob - oa, s_lon, unused);
		rotate_angle(2 * la, unused, c_a);
		rotate_angle(2 * lb, unused, c_b);
		a = q30_product(s_lat, s_lat) +
			q30_product(q30_product(c_a, c_b), q30_product(s_lon, s_lon));
		if (a < 0)
			a = 0;
		if (a > (longint'(1) << 30))
			a = longint'(1) << 30;
		x = root_q30((longint'(1) << 30) - a);
		y = root_q30(a);
		for (int i = 0; i < Iters; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += stage_angle(i);
			end else begin
				x -= dx; y += dy; z -= stage_angle(i);
			end
		end
		if (z < 0)
			z = 0;
		p = 64'(rad) * 64'(2 * z);
		mm = (p >> 30) * 1000 + ((((p & 64'h3FFF_FFFF) * 1000) + (64'd1 << 29)) >> 30);
		if (mm > 64'd26353590000)
			mm = 64'd26353590000;
		exp_mm = mm[DistW-1:0];
	endtask

	assign pending_count = expected_distances.size();

	// Track the radius, predict on input beats, compare on output beats.
	always @(posedge clk or negedge arst_n) begin
		logic [DistW-1:0] want;
		if (!arst_n) begin
			radius_m <= RadiusReset;
			fail_count <= 0;
			expected_distances.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				radius_m <= cfg_data;
			if (in_valid && !in_stall) begin
				predict_distance(lat_a, lon_a, lat_b, lon_b, radius_m, want);
				expected_distances.insert(expected_distances.size(), want);
			end
			if (out_valid && !out_stall) begin
				if (expected_distances.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected distance beat %0d", distance_mm);
				end else begin
					want = expected_distances.pop_front();
					if (want !== distance_mm) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("distance_mm mismatch: expected %0d got %0d",
								want, distance_mm);
					end
				end
			end
		end
	end
endmodule

// ===== test/testbench.sv =====
//------------------------------------------------------------------------------
// Haversine distance testbench
// Drives point pairs and radius writes into the distance unit under varying
// flow control; a checker beside it predicts and compares every distance.
//------------------------------------------------------------------------------
module testbench;
	import hav_pkg::*;

	localparam int Latency = 2 * CordicItersDefault + 45;
	localparam int LatMax  = 900000000;
	localparam int LonMax  = 1800000000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [LatW-1:0]   lat_a;
	logic signed [LonW-1:0]   lon_a;
	logic signed [LatW-1:0]   lat_b;
	logic signed [LonW-1:0]   lon_b;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [DistW-1:0]         distance_mm;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [RadW-1:0]          cfg_data;
	int                       fail_count;
	int                       pending_count;
	int                       send_idle_pct;
	int                       recv_idle_pct;
	longint                   cycle_count = 0;

	haversine_distance_unit u_top (.*);

	haversine_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Receiver stall at the current idling rate.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Send one point pair, with random gaps before it.
	task automatic send_pair(input logic [LatW-1:0] la, input logic [LonW-1:0] oa,
		input logic [LatW-1:0] lb, input logic [LonW-1:0] ob);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		lat_a <= la;
		lon_a <= oa;
		lat_b <= lb;
		lon_b <= ob;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (Latency) @(posedge clk);
	endtask

	task automatic write_radius(input logic [RadW-1:0] r);
		cfg_valid <= 1;
		cfg_data <= r;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [LatW-1:0] rand_lat();
		return LatW'($urandom_range(2 * LatMax) - LatMax);
	endfunction

	function automatic logic [LonW-1:0] rand_lon();
		return LonW'($urandom_range(2 * LonMax) - LonMax);
	endfunction

	// Random pairs: mostly valid coordinates, some near-coincident, some raw bits.
	task automatic random_pairs(input int n);
		logic [LatW-1:0] la;
		logic [LonW-1:0] oa;
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(9);
			la = rand_lat();
			oa = rand_lon();
			if (kind < 6)
				send_pair(la, oa, rand_lat(), rand_lon());
			else if (kind < 8)
				send_pair(la, oa, la + LatW'($urandom_range(2000) - 1000),
					oa + LonW'($urandom_range(2000) - 1000));
			else
				send_pair(LatW'($urandom), $urandom, LatW'($urandom), $urandom);
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		lat_a = 0;
		lon_a = 0;
		lat_b = 0;
		lon_b = 0;
		cfg_valid = 0;
		cfg_data = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: poles, antipodes, date line, identical points, raw extremes.
		send_pair(0, 0, 0, 0);
		send_pair(LatMax, 0, -LatMax, 0);
		send_pair(0, 0, 0, LonMax);
		send_pair(0, LonMax, 0, -LonMax);
		send_pair(0, -LonMax, 0, LonMax);
		send_pair(LatMax, LonMax, LatMax, -LonMax);
		send_pair(-LatMax, 123, LatMax, -456);
		send_pair(1, 0, 0, 1);
		send_pair(31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000);
		send_pair(31'h4000_0000, 32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF);
		send_pair(31'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		send_pair(LatMax + 5000000, 0, -LatMax - 5000000, 10);
		send_pair(515000000, -1270000, 407000000, -740000000);
		drain();

		// Radius extremes, including zero and full scale.
		write_radius(23'h7FFFFF);
		send_pair(0, 0, 0, LonMax);
		send_pair(LatMax, 0, -LatMax, 0);
		send_pair(1000, 2000, -3000, 4000);
		drain();
		write_radius(0);
		send_pair(0, 0, 0, LonMax);
		send_pair(LatMax, 0, 0, 0);
		drain();
		write_radius(1);
		send_pair(0, 0, 0, LonMax);
		send_pair(0, 0, 10, 10);
		drain();
		write_radius(RadiusReset);

		send_idle_pct = 27;
		recv_idle_pct = 61;
		random_pairs(130);
		drain();
		write_radius(RadW'($urandom));
		send_idle_pct = 61;
		recv_idle_pct = 27;
		random_pairs(130);
		drain();
		write_radius(23'h7FFFFF);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_pairs(140);
		drain();

		if (fail_count == 0 && pending_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/hav_pkg.sv
rtl/hav_sincos.sv
rtl/hav_sqrt.sv
rtl/haversine_distance_unit.sv
test/haversine_checker.sv
test/testbench.sv
